@@ rtl/core/stt_pkg.sv @@
package stt_pkg;

  localparam int COUNTER_BITS_DEF = 20;
  localparam int FIELD_W = 20;

  // Result queue between the scanner and the output port.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W = $clog2(QUEUE_DEPTH + 1);

  // Keyword spellings, first character in the most significant byte.
  localparam logic [47:0] KW_RETURN = "return";
  localparam logic [47:0] KW_STRUCT = "struct";
  localparam logic [31:0] KW_PROC = "proc";
  localparam logic [23:0] KW_NEW = "new";

  typedef enum logic [4:0] {
    KIND_END     = 5'd0,
    KIND_INVALID = 5'd1,
    KIND_STRING  = 5'd2,
    KIND_HEX     = 5'd3,
    KIND_BIN     = 5'd4,
    KIND_OCT     = 5'd5,
    KIND_INT     = 5'd6,
    KIND_FLOAT   = 5'd7,
    KIND_IDENT   = 5'd8,
    KIND_DEF     = 5'd9,
    KIND_LBRACE  = 5'd10,
    KIND_RBRACE  = 5'd11,
    KIND_LPAREN  = 5'd12,
    KIND_RPAREN  = 5'd13,
    KIND_LBRACK  = 5'd14,
    KIND_RBRACK  = 5'd15,
    KIND_OPER    = 5'd16,
    KIND_COMMA   = 5'd17,
    KIND_SEMI    = 5'd18,
    KIND_RETURN  = 5'd19,
    KIND_PROC    = 5'd20,
    KIND_STRUCT  = 5'd21,
    KIND_NEW     = 5'd22
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_COMMENT = 4'd1,
    PH_IDENT   = 4'd2,
    PH_ZERO    = 4'd3,
    PH_HEX     = 4'd4,
    PH_BIN     = 4'd5,
    PH_OCT     = 4'd6,
    PH_DEC     = 4'd7,
    PH_STR     = 4'd8,
    PH_OP_LT   = 4'd9,
    PH_OP_GT   = 4'd10,
    PH_OP_EQ   = 4'd11,
    PH_OP_AND  = 4'd12,
    PH_OP_OR   = 4'd13
  } phase_t;

  typedef struct packed {
    kind_t              kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] column;
    logic               last;
  } token_t;

  // Up to two tokens produced by one byte, in order.
  typedef struct packed {
    token_t [1:0] tok;
    logic [1:0]   count;
  } scan_out_t;

  typedef struct packed {
    logic                room;
    logic                nonempty;
    logic [QLEVEL_W-1:0] level;
  } q_status_t;

endpackage

@@ rtl/core/stt_scanner.sv @@
module stt_scanner #(
  parameter int COUNTER_BITS = stt_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              mode,
  input  logic [7:0]        text_byte,
  output stt_pkg::scan_out_t result
);
  import stt_pkg::*;

  localparam int CB = COUNTER_BITS;
  typedef logic [CB-1:0] cnt_t;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_QUOTE = "\"";
  localparam logic [7:0] CH_BSLASH = "\\";

  phase_t      phase, phase_next;
  kind_t       pend_kind, pend_kind_next;
  cnt_t        bpos, bpos_next;
  cnt_t        line_cnt, line_cnt_next;
  cnt_t        col_cnt, col_cnt_next;
  cnt_t        spos, spos_next;
  cnt_t        sline, sline_next;
  cnt_t        scol, scol_next;
  logic [47:0] kw_win, kw_win_next;
  logic        seen_dot, seen_dot_next;
  logic        esc, esc_next;
  logic        err, err_next;

  function automatic cnt_t bump(input cnt_t v);
    bump = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [FIELD_W-1:0] clip(input cnt_t v);
    logic [CB+FIELD_W-1:0] wide;
    logic [CB+FIELD_W-1:0] lim;
    wide = {{FIELD_W{1'b0}}, v};
    lim = {{CB{1'b0}}, {FIELD_W{1'b1}}};
    if (wide > lim) begin
      clip = '1;
    end else begin
      clip = wide[FIELD_W-1:0];
    end
  endfunction

  function automatic token_t make_tok(input kind_t k, input cnt_t s, input cnt_t len,
                                     input cnt_t ln, input cnt_t col);
    token_t t;
    t.kind = k;
    t.start = clip(s);
    t.length = clip(len);
    t.line = clip(ln);
    t.column = clip(col);
    t.last = 1'b0;
    make_tok = t;
  endfunction

  function automatic kind_t ident_kind(input cnt_t len, input logic [47:0] w);
    kind_t k;
    k = KIND_IDENT;
    if (len == cnt_t'(6) && w == KW_RETURN) k = KIND_RETURN;
    else if (len == cnt_t'(4) && w[31:0] == KW_PROC) k = KIND_PROC;
    else if (len == cnt_t'(6) && w == KW_STRUCT) k = KIND_STRUCT;
    else if (len == cnt_t'(3) && w[23:0] == KW_NEW) k = KIND_NEW;
    ident_kind = k;
  endfunction

  logic       is_letter, is_digit, is_hex, is_octal, is_blank;
  logic       op_hit;
  logic [2:0] op_idx, op_stage;
  cnt_t       close_len;
  kind_t      close_kind;
  kind_t      single;
  token_t     toks [2];
  logic [1:0] cnt;
  logic       consumed, do_close;

  assign is_letter = (text_byte >= "a" && text_byte <= "z") ||
                     (text_byte >= "A" && text_byte <= "Z") || text_byte == "_";
  assign is_digit = text_byte >= "0" && text_byte <= "9";
  assign is_hex = is_digit || (text_byte >= "a" && text_byte <= "f") ||
                  (text_byte >= "A" && text_byte <= "F");
  assign is_octal = text_byte >= "0" && text_byte <= "7";
  assign is_blank = text_byte == CH_SPACE || text_byte == CH_TAB ||
                    text_byte == CH_LF || text_byte == CH_CR;

  // Position of the byte in the operator chain < > = & |.
  always_comb begin
    op_hit = 1'b1;
    op_idx = 3'd0;
    unique case (text_byte)
      "<": op_idx = 3'd0;
      ">": op_idx = 3'd1;
      "=": op_idx = 3'd2;
      "&": op_idx = 3'd3;
      "|": op_idx = 3'd4;
      default: op_hit = 1'b0;
    endcase
  end

  assign op_stage = 3'(phase - PH_OP_LT);
  assign close_len = bpos - spos;
  assign close_kind = (phase == PH_IDENT) ? ident_kind(close_len, kw_win) : pend_kind;

  always_comb begin
    phase_next = phase;
    pend_kind_next = pend_kind;
    bpos_next = bpos;
    line_cnt_next = line_cnt;
    col_cnt_next = col_cnt;
    spos_next = spos;
    sline_next = sline;
    scol_next = scol;
    kw_win_next = kw_win;
    seen_dot_next = seen_dot;
    esc_next = esc;
    err_next = err;
    toks[0] = '0;
    toks[1] = '0;
    cnt = 2'd0;
    consumed = 1'b0;
    do_close = 1'b0;
    single = KIND_INVALID;

    if (step) begin
      if (mode) begin
        if (!err && phase == PH_STR) begin
          // An unterminated string is reported as the end token alone.
          toks[0] = make_tok(KIND_END, spos, close_len, sline, scol);
          cnt = 2'd1;
        end else begin
          if (!err && phase != PH_IDLE && phase != PH_COMMENT) begin
            toks[0] = make_tok(close_kind, spos, close_len, sline, scol);
            cnt = 2'd1;
          end
          toks[cnt[0]] = make_tok(KIND_END, bpos, '0, line_cnt, col_cnt);
          cnt = cnt + 2'd1;
        end
        phase_next = PH_IDLE;
        pend_kind_next = KIND_END;
        bpos_next = '0;
        line_cnt_next = '0;
        col_cnt_next = '0;
        spos_next = '0;
        sline_next = '0;
        scol_next = '0;
        kw_win_next = '0;
        seen_dot_next = 1'b0;
        esc_next = 1'b0;
        err_next = 1'b0;
      end else begin
        if (!err) begin
          unique case (phase)
            PH_IDLE: ;
            PH_COMMENT: begin
              if (text_byte == CH_LF || text_byte == CH_CR) phase_next = PH_IDLE;
              else consumed = 1'b1;
            end
            PH_IDENT: begin
              if (is_letter || is_digit) begin
                kw_win_next = {kw_win[39:0], text_byte};
                consumed = 1'b1;
              end else do_close = 1'b1;
            end
            PH_ZERO: begin
              if (text_byte == "x") begin
                phase_next = PH_HEX;
                pend_kind_next = KIND_HEX;
                consumed = 1'b1;
              end else if (text_byte == "b") begin
                phase_next = PH_BIN;
                pend_kind_next = KIND_BIN;
                consumed = 1'b1;
              end else if (is_octal) begin
                phase_next = PH_OCT;
                consumed = 1'b1;
              end else do_close = 1'b1;
            end
            PH_HEX: begin
              if (is_hex) consumed = 1'b1;
              else do_close = 1'b1;
            end
            PH_BIN: begin
              if (text_byte == "0" || text_byte == "1") consumed = 1'b1;
              else do_close = 1'b1;
            end
            PH_OCT: begin
              if (is_octal) consumed = 1'b1;
              else do_close = 1'b1;
            end
            PH_DEC: begin
              if (is_digit) consumed = 1'b1;
              else if (text_byte == "." && !seen_dot) begin
                seen_dot_next = 1'b1;
                pend_kind_next = KIND_FLOAT;
                consumed = 1'b1;
              end else do_close = 1'b1;
            end
            PH_STR: begin
              consumed = 1'b1;
              if (esc) esc_next = 1'b0;
              else if (text_byte == CH_BSLASH) esc_next = 1'b1;
              else if (text_byte == CH_QUOTE) begin
                toks[0] = make_tok(KIND_STRING, spos, bump(bpos) - spos, sline, scol);
                cnt = 2'd1;
                phase_next = PH_IDLE;
              end
            end
            PH_OP_LT, PH_OP_GT, PH_OP_EQ, PH_OP_AND, PH_OP_OR: begin
              // A byte at the current stage or any later one extends the operator.
              if (op_hit && op_idx >= op_stage) begin
                consumed = 1'b1;
                unique case (op_idx)
                  3'd0: phase_next = PH_OP_GT;
                  3'd1: phase_next = PH_OP_EQ;
                  3'd2: phase_next = PH_OP_AND;
                  3'd3: phase_next = PH_OP_OR;
                  default: begin
                    toks[0] = make_tok(KIND_OPER, spos, bump(bpos) - spos, sline, scol);
                    cnt = 2'd1;
                    phase_next = PH_IDLE;
                  end
                endcase
              end else do_close = 1'b1;
            end
            default: phase_next = PH_IDLE;
          endcase

          if (do_close) begin
            toks[0] = make_tok(close_kind, spos, close_len, sline, scol);
            cnt = 2'd1;
            phase_next = PH_IDLE;
          end

          if (!consumed) begin
            spos_next = bpos;
            sline_next = line_cnt;
            scol_next = col_cnt;
            priority if (is_blank) begin
            end else if (text_byte == "#") begin
              phase_next = PH_COMMENT;
            end else if (text_byte == "0") begin
              phase_next = PH_ZERO;
              pend_kind_next = KIND_OCT;
            end else if (is_digit || text_byte == ".") begin
              phase_next = PH_DEC;
              seen_dot_next = (text_byte == ".");
              pend_kind_next = (text_byte == ".") ? KIND_FLOAT : KIND_INT;
            end else if (text_byte == CH_QUOTE) begin
              phase_next = PH_STR;
              esc_next = 1'b0;
            end else if (is_letter) begin
              phase_next = PH_IDENT;
              kw_win_next = {40'd0, text_byte};
            end else if (text_byte == "!" || text_byte == "<") begin
              phase_next = PH_OP_LT;
              pend_kind_next = KIND_OPER;
            end else if (text_byte == ">") begin
              phase_next = PH_OP_GT;
              pend_kind_next = KIND_OPER;
            end else if (text_byte == "=") begin
              phase_next = PH_OP_EQ;
              pend_kind_next = KIND_OPER;
            end else if (text_byte == "&") begin
              phase_next = PH_OP_AND;
              pend_kind_next = KIND_OPER;
            end else if (text_byte == "|") begin
              phase_next = PH_OP_OR;
              pend_kind_next = KIND_OPER;
            end else begin
              unique case (text_byte)
                ":": single = KIND_DEF;
                "{": single = KIND_LBRACE;
                "}": single = KIND_RBRACE;
                "(": single = KIND_LPAREN;
                ")": single = KIND_RPAREN;
                "[": single = KIND_LBRACK;
                "]": single = KIND_RBRACK;
                ",": single = KIND_COMMA;
                ";": single = KIND_SEMI;
                "^", "+", "-", "*", "/", "%": single = KIND_OPER;
                default: single = KIND_INVALID;
              endcase
              if (single == KIND_INVALID) err_next = 1'b1;
              toks[cnt[0]] = make_tok(single, bpos, bump(bpos) - bpos, line_cnt, col_cnt);
              cnt = cnt + 2'd1;
            end
          end
        end

        bpos_next = bump(bpos);
        if (text_byte == CH_LF) begin
          line_cnt_next = bump(line_cnt);
          col_cnt_next = '0;
        end else begin
          col_cnt_next = bump(col_cnt);
        end
      end
    end

    if (cnt == 2'd2) toks[1].last = 1'b1;
    else toks[0].last = 1'b1;
  end

  always_comb begin
    result.tok[0] = toks[0];
    result.tok[1] = toks[1];
    result.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pend_kind <= KIND_END;
      bpos <= '0;
      line_cnt <= '0;
      col_cnt <= '0;
      spos <= '0;
      sline <= '0;
      scol <= '0;
      kw_win <= '0;
      seen_dot <= 1'b0;
      esc <= 1'b0;
      err <= 1'b0;
    end else begin
      phase <= phase_next;
      pend_kind <= pend_kind_next;
      bpos <= bpos_next;
      line_cnt <= line_cnt_next;
      col_cnt <= col_cnt_next;
      spos <= spos_next;
      sline <= sline_next;
      scol <= scol_next;
      kw_win <= kw_win_next;
      seen_dot <= seen_dot_next;
      esc <= esc_next;
      err <= err_next;
    end
  end

endmodule

@@ rtl/core/stt_result_queue.sv @@
module stt_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  stt_pkg::scan_out_t push,
  input  logic               pop,
  output stt_pkg::token_t    head,
  output stt_pkg::q_status_t status
);
  import stt_pkg::*;

  token_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [QPTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [QLEVEL_W-1:0] level, level_next;

  always_comb begin
    wr_ptr_next = wr_ptr + QPTR_W'(push.count);
    rd_ptr_next = rd_ptr + QPTR_W'(pop);
    level_next = level + QLEVEL_W'(push.count) - QLEVEL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.tok[0];
    if (push.count == 2'd2) mem[wr_ptr + QPTR_W'(1)] <= push.tok[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      level <= level_next;
    end
  end

  assign head = mem[rd_ptr];
  assign status.level = level;
  assign status.nonempty = level != '0;
  assign status.room = level <= QLEVEL_W'(QUEUE_DEPTH - 2);

endmodule

@@ rtl/core/source_text_tokenizer_top.sv @@
// A byte waits in the input register until the queue has room, and the tokens it makes
// are then written into the result queue, from whose head they leave on the output.
// Throughput: one byte or end-of-text mark per cycle. Results leave at one per cycle, so only
// a stalled receiver or a run of bytes that each make two tokens fills the four-entry queue
// and stalls the input. Reset (synchronous, active high) returns the scanner to idle with
// all counters at zero and empties the result queue.
module source_text_tokenizer_top #(
  parameter int COUNTER_BITS = stt_pkg::COUNTER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [7:0]                  text_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [4:0]                  token_kind,
  output logic [stt_pkg::FIELD_W-1:0] token_start,
  output logic [stt_pkg::FIELD_W-1:0] token_length,
  output logic [stt_pkg::FIELD_W-1:0] token_line,
  output logic [stt_pkg::FIELD_W-1:0] token_column,
  output logic                        run_last
);
  import stt_pkg::*;

  // Input register. A transaction lands here and is scanned in the following
  // cycle as long as the result queue can absorb the two tokens a byte may make.
  logic       in_q_valid;
  logic       in_q_mode;
  logic [7:0] in_q_byte;
  logic       accept;
  logic       advance;
  logic       pop;

  scan_out_t  scan;
  token_t     head;
  q_status_t  qstat;

  assign advance = in_q_valid && qstat.room;
  assign in_stall = in_q_valid && !qstat.room;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= accept || (in_q_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_mode <= mode;
      in_q_byte <= text_byte;
    end
  end

  // The scanner updates its state and produces the tokens for one byte per step.
  stt_scanner #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_scanner (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .mode     (in_q_mode),
    .text_byte(in_q_byte),
    .result   (scan)
  );

  // The result queue decouples the output transaction from the scanner.
  stt_result_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (scan),
    .pop   (pop),
    .head  (head),
    .status(qstat)
  );

  assign out_valid = qstat.nonempty;
  assign pop = out_valid && !out_stall;

  assign token_kind = head.kind;
  assign token_start = head.start;
  assign token_length = head.length;
  assign token_line = head.line;
  assign token_column = head.column;
  assign run_last = head.last;

`ifndef SYNTH
  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.level <= QLEVEL_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // The queue level tracks exactly what was pushed and popped.
  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> qstat.level == QLEVEL_W'($past(qstat.level)
      + QLEVEL_W'($past(scan.count)) - QLEVEL_W'($past(pop))))
    else $error("result queue level out of step");

  // An end-of-text step always finishes with an end token.
  a_end_token: assert property (@(posedge clk) disable iff (rst)
    advance && in_q_mode |->
      (scan.count == 2'd1 && scan.tok[0].kind == KIND_END) ||
      (scan.count == 2'd2 && scan.tok[1].kind == KIND_END))
    else $error("end of text without end token");

  // A step is only taken when the queue has room for two tokens.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    scan.count != 2'd0 |-> qstat.room)
    else $error("tokens pushed without room");
`endif

endmodule

@@ dv/tb_source_text_tokenizer_top.sv @@
`timescale 1ns / 100ps

module tb_source_text_tokenizer_top;
  import stt_pkg::*;

  typedef logic [FIELD_W-1:0] count_t;

  // Operator chain stages in order, first stage in the top byte.
  localparam logic [39:0] OP_CHAIN = "<>=&|";
  localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

  // The checker keeps a shadow copy of the scanner. Every accepted input transaction is
  // run through it, and the tokens that it yields wait in tokens_due until the block
  // hands out the matching output transactions.
  class token_checker;
    token_t   tokens_due[$];
    token_t   step_tokens[$];
    int       n_bad;
    phase_t   phase;
    kind_t    pend_kind;
    count_t   pos, line_no, col_no;
    count_t   tok_pos, tok_row, tok_col;
    logic [47:0] kw_win;
    bit       seen_dot, esc, err;

    function new();
      n_bad = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase = PH_IDLE;
      pend_kind = KIND_END;
      pos = '0;
      line_no = '0;
      col_no = '0;
      tok_pos = '0;
      tok_row = '0;
      tok_col = '0;
      kw_win = '0;
      seen_dot = 1'b0;
      esc = 1'b0;
      err = 1'b0;
    endfunction

    function count_t bump(count_t v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function bit is_letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function void put(kind_t k, count_t st, count_t len, count_t ln, count_t cl);
      token_t t;
      t.kind = k;
      t.start = st;
      t.length = len;
      t.line = ln;
      t.column = cl;
      t.last = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void emit(kind_t k, count_t end_pos);
      put(k, tok_pos, (end_pos >= tok_pos) ? end_pos - tok_pos : '0, tok_row, tok_col);
    endfunction

    function kind_t word_kind(count_t len);
      if (len == 6 && kw_win == KW_RETURN) return KIND_RETURN;
      if (len == 4 && kw_win[31:0] == KW_PROC) return KIND_PROC;
      if (len == 6 && kw_win == KW_STRUCT) return KIND_STRUCT;
      if (len == 3 && kw_win[23:0] == KW_NEW) return KIND_NEW;
      return KIND_IDENT;
    endfunction

    function void close_open();
      kind_t k;
      k = pend_kind;
      if (phase == PH_IDENT) k = word_kind(pos - tok_pos);
      emit(k, pos);
      phase = PH_IDLE;
    endfunction

    // Offers a byte to the open token and returns 1 if the token takes it.
    function bit extend_open(logic [7:0] b);
      case (phase)
        PH_IDLE: return 1'b0;
        PH_COMMENT: begin
          if (b == "\n" || b == "\r") begin
            phase = PH_IDLE;
            return 1'b0;
          end
          return 1'b1;
        end
        PH_IDENT: begin
          if (is_letter(b) || is_digit(b)) begin
            kw_win = {kw_win[39:0], b};
            return 1'b1;
          end
        end
        PH_ZERO: begin
          if (b == "x") begin
            phase = PH_HEX;
            pend_kind = KIND_HEX;
            return 1'b1;
          end
          if (b == "b") begin
            phase = PH_BIN;
            pend_kind = KIND_BIN;
            return 1'b1;
          end
          if (b >= "0" && b <= "7") begin
            phase = PH_OCT;
            return 1'b1;
          end
        end
        PH_HEX: begin
          if (is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F")) return 1'b1;
        end
        PH_BIN: begin
          if (b == "0" || b == "1") return 1'b1;
        end
        PH_OCT: begin
          if (b >= "0" && b <= "7") return 1'b1;
        end
        PH_DEC: begin
          if (is_digit(b)) return 1'b1;
          if (b == "." && !seen_dot) begin
            seen_dot = 1'b1;
            pend_kind = KIND_FLOAT;
            return 1'b1;
          end
        end
        PH_STR: begin
          if (esc) begin
            esc = 1'b0;
          end else if (b == "\\") begin
            esc = 1'b1;
          end else if (b == "\"") begin
            emit(KIND_STRING, bump(pos));
            phase = PH_IDLE;
          end
          return 1'b1;
        end
        default: begin
          for (int j = phase - PH_OP_LT; j < 5; j++) begin
            if (OP_CHAIN[39 - 8 * j -: 8] == b) begin
              if (j == 4) begin
                emit(KIND_OPER, bump(pos));
                phase = PH_IDLE;
              end else begin
                phase = phase_t'(PH_OP_LT + j + 1);
              end
              return 1'b1;
            end
          end
        end
      endcase
      close_open();
      return 1'b0;
    endfunction

    function void start_open(logic [7:0] b);
      kind_t one_kind;
      tok_pos = pos;
      tok_row = line_no;
      tok_col = col_no;
      if (b == " " || b == "\t" || b == "\n" || b == "\r") return;
      if (b == "#") begin
        phase = PH_COMMENT;
        return;
      end
      if (b == "0") begin
        phase = PH_ZERO;
        pend_kind = KIND_OCT;
        return;
      end
      if (is_digit(b) || b == ".") begin
        phase = PH_DEC;
        seen_dot = (b == ".");
        if (seen_dot) pend_kind = KIND_FLOAT;
        else pend_kind = KIND_INT;
        return;
      end
      if (b == "\"") begin
        phase = PH_STR;
        esc = 1'b0;
        return;
      end
      if (is_letter(b)) begin
        phase = PH_IDENT;
        kw_win = {40'd0, b};
        return;
      end
      case (b)
        "!", "<": begin
          phase = PH_OP_LT;
          pend_kind = KIND_OPER;
          return;
        end
        ">": begin
          phase = PH_OP_GT;
          pend_kind = KIND_OPER;
          return;
        end
        "=": begin
          phase = PH_OP_EQ;
          pend_kind = KIND_OPER;
          return;
        end
        "&": begin
          phase = PH_OP_AND;
          pend_kind = KIND_OPER;
          return;
        end
        "|": begin
          phase = PH_OP_OR;
          pend_kind = KIND_OPER;
          return;
        end
        ":": one_kind = KIND_DEF;
        "{": one_kind = KIND_LBRACE;
        "}": one_kind = KIND_RBRACE;
        "(": one_kind = KIND_LPAREN;
        ")": one_kind = KIND_RPAREN;
        "[": one_kind = KIND_LBRACK;
        "]": one_kind = KIND_RBRACK;
        ",": one_kind = KIND_COMMA;
        ";": one_kind = KIND_SEMI;
        "^", "+", "-", "*", "/", "%": one_kind = KIND_OPER;
        default: begin
          one_kind = KIND_INVALID;
          err = 1'b1;
        end
      endcase
      emit(one_kind, bump(pos));
    endfunction

    // Notes one accepted input transaction and queues the tokens it completes.
    function void take_input(logic m, logic [7:0] b);
      step_tokens.delete();
      if (m) begin
        if (!err && phase == PH_STR) begin
          emit(KIND_END, pos);
        end else begin
          if (!err && phase != PH_IDLE && phase != PH_COMMENT) close_open();
          put(KIND_END, pos, '0, line_no, col_no);
        end
        clear_state();
      end else begin
        if (!err && !extend_open(b)) start_open(b);
        pos = bump(pos);
        if (b == "\n") begin
          line_no = bump(line_no);
          col_no = '0;
        end else begin
          col_no = bump(col_no);
        end
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
      foreach (step_tokens[i]) tokens_due.push_back(step_tokens[i]);
    endfunction

    function string show(token_t t);
      return $sformatf("kind %0d start %0d length %0d line %0d column %0d last %0b",
                       t.kind, t.start, t.length, t.line, t.column, t.last);
    endfunction

    function void report(string msg);
      n_bad++;
      if (n_bad <= 10) $display("%s", msg);
    endfunction

    // Checks one output transaction against the oldest token still due.
    function void check_token(token_t got);
      token_t want;
      if (tokens_due.size() == 0) begin
        report({"unexpected token: ", show(got)});
        return;
      end
      want = tokens_due.pop_front();
      if (got.kind !== want.kind || got.start !== want.start || got.length !== want.length ||
          got.line !== want.line || got.column !== want.column || got.last !== want.last)
        report({"token mismatch: expected ", show(want), "; got ", show(got)});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  logic [7:0]  text_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  token_kind;
  count_t      token_start, token_length, token_line, token_column;
  logic        run_last;

  token_checker tokens = new();
  token_t       seen_token;
  logic [7:0]   text_bytes[$];
  int           sender_idle_pct = 0;
  int           stall_pct = 0;
  int unsigned  items_sent = 0;

  always #4 clk = ~clk;

  source_text_tokenizer_top u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .text_byte   (text_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .token_start (token_start),
    .token_length(token_length),
    .token_line  (token_line),
    .token_column(token_column),
    .run_last    (run_last)
  );

  // The receiver stalls at random with the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both handshakes are sampled at the rising edge, before any of this edge's
  // nonblocking updates land, so the values seen are the ones the block saw.
  // The input side is noted first so that its tokens are due before any check.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tokens.take_input(mode, text_byte);
      if (out_valid && !out_stall) begin
        seen_token.kind = kind_t'(token_kind);
        seen_token.start = token_start;
        seen_token.length = token_length;
        seen_token.line = token_line;
        seen_token.column = token_column;
        seen_token.last = run_last;
        tokens.check_token(seen_token);
      end
    end
  end

  // Sends one input transaction. Idle cycles come first, at the current rate, and
  // the payload then stays put until the block takes it.
  task automatic send_item(logic m, logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    text_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Sends the collected text bytes and then the end-of-text mark. The byte that
  // travels with the mark is random, since the block must ignore it.
  task automatic send_text();
    foreach (text_bytes[i]) send_item(1'b0, text_bytes[i]);
    send_item(1'b1, 8'($urandom_range(255)));
    text_bytes.delete();
  endtask

  // The sender holds off until every token that is due has come out.
  task automatic wait_for_tokens();
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens.tokens_due.size() != 0);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endfunction

  // String contents mix plain characters, escapes of any byte and raw bytes of
  // any value. A raw quote or backslash just changes where the string ends.
  function automatic void add_string_body();
    repeat ($urandom_range(8)) begin
      case ($urandom_range(3))
        0: text_bytes.push_back(pick(ALNUM));
        1: begin
          text_bytes.push_back("\\");
          text_bytes.push_back(8'($urandom_range(255)));
        end
        2: text_bytes.push_back(8'($urandom_range(255)));
        default: text_bytes.push_back(" ");
      endcase
    end
  endfunction

  // Appends one well-formed lexeme, sometimes a near miss, and then maybe a
  // separator. Without a separator the next lexeme closes this one, so a single
  // byte often ends one token and emits another.
  function automatic void add_fragment();
    string word;
    case ($urandom_range(13))
      0, 1: begin
        text_bytes.push_back(pick(LETTERS));
        repeat ($urandom_range(7)) text_bytes.push_back(pick(ALNUM));
      end
      2: begin
        case ($urandom_range(3))
          0: word = "return";
          1: word = "proc";
          2: word = "struct";
          default: word = "new";
        endcase
        // Keywords must match exactly, so drop or add a letter now and then.
        case ($urandom_range(3))
          0: word = word.substr(0, word.len() - 2);
          1: word = {word, "s"};
          default: ;
        endcase
        add_str(word);
      end
      3: begin
        text_bytes.push_back(pick("123456789"));
        repeat ($urandom_range(5)) text_bytes.push_back(pick("0123456789"));
      end
      4: begin
        // A lone dot is a float too, and a second dot starts a new float.
        if ($urandom_range(1)) text_bytes.push_back(pick("123456789"));
        text_bytes.push_back(".");
        repeat ($urandom_range(3)) text_bytes.push_back(pick("0123456789"));
        if ($urandom_range(3) == 0) text_bytes.push_back(".");
      end
      5: begin
        add_str("0x");
        repeat ($urandom_range(6)) text_bytes.push_back(pick("0123456789abcdefABCDEFg"));
      end
      6: begin
        add_str("0b");
        repeat ($urandom_range(8)) text_bytes.push_back(pick("01012"));
      end
      7: begin
        text_bytes.push_back("0");
        repeat ($urandom_range(4)) text_bytes.push_back(pick("012345678"));
      end
      8: begin
        text_bytes.push_back("\"");
        add_string_body();
        text_bytes.push_back("\"");
      end
      9: begin
        text_bytes.push_back("#");
        repeat ($urandom_range(8)) text_bytes.push_back(8'($urandom_range(255)));
        text_bytes.push_back(pick("\n\r"));
      end
      10, 11: begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(3) == 0) text_bytes.push_back(pick("^+-*/%"));
          else text_bytes.push_back(pick("!<>=&|"));
        end
      end
      12: text_bytes.push_back(pick(":{}()[],;"));
      default: text_bytes.push_back(pick(" \t\n\r"));
    endcase
    case ($urandom_range(3))
      0: text_bytes.push_back(" ");
      1: text_bytes.push_back("\n");
      2: text_bytes.push_back(pick("\t\r"));
      default: ;
    endcase
  endfunction

  // One random text: mostly clean lexemes, rarely a stray byte that may be
  // invalid, and sometimes an open string or comment left at end of text.
  task automatic run_text();
    repeat ($urandom_range(14)) add_fragment();
    if ($urandom_range(24) == 0)
      text_bytes.insert($urandom_range(text_bytes.size()), 8'($urandom_range(255)));
    case ($urandom_range(5))
      0: begin
        text_bytes.push_back("\"");
        add_string_body();
      end
      1: begin
        text_bytes.push_back("#");
        repeat ($urandom_range(4)) text_bytes.push_back(pick(ALNUM));
      end
      default: ;
    endcase
    send_text();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first phase has a lazy receiver and a busy sender.
    sender_idle_pct = 16;
    stall_pct = 82;

    // Directed text: hex, binary, octal and float numbers, a string with an escaped quote, and a
    // comment that only end of text closes.
    add_str("0x1f 0b1 07 9.5 \"a\\\"\"#c");
    send_text();
    // The highest byte is invalid and latches the error, so the zero byte after
    // it is ignored and end of text gives just the end token.
    text_bytes.push_back(8'hFF);
    text_bytes.push_back(8'h00);
    send_text();

    while (items_sent < 550) run_text();
    wait_for_tokens();

    // The second phase turns the rates around.
    sender_idle_pct = 82;
    stall_pct = 16;
    while (items_sent < 1100) run_text();
    wait_for_tokens();

    // The last phase runs at full rate on both sides.
    sender_idle_pct = 0;
    stall_pct = 0;
    while (items_sent < 1650) run_text();
    wait_for_tokens();

    // A few more cycles catch any token that the block should not have sent.
    repeat (16) @(posedge clk);
    if (tokens.n_bad == 0 && tokens.tokens_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // A hang anywhere ends the run as a failure.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
